@@ rtl/ndf_pkg.sv @@
// ----------------------------------------------------------------------------
// Netstring deframer package
// Shared widths, character codes, phase codes and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ndf_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 24;
  localparam int ACC_W    = LEN_W + 1;
  localparam int PROD_W   = ACC_W + 4;
  localparam int DIGIT_W  = 4;
  localparam int ERR_W    = 3;
  localparam int PHASE_W  = 2;

  localparam logic [DIGIT_W-1:0] MAX_DIGITS = 4'd15;
  localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 24'd65536;

  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2c;

  localparam logic [PHASE_W-1:0] PH_LENGTH = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DATA   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COMMA  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FAILED = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_COLON   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY_LEN  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_END_IN_DATA = 3'd5;
  localparam logic [ERR_W-1:0] ERR_NO_COMMA   = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              string_done;
    logic [LEN_W-1:0]  string_length;
    logic [ERR_W-1:0]  error_code;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/netstring_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// Netstring deframer unit
// Splits a byte stream of back-to-back netstrings (length ':' data ',') into
// payload bytes, completion results and a single sticky error result.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | byte_in, end_of_stream
//  result   | out_valid / out_ready| data_byte, data_valid, string_done,
//           |                      | string_length, error_code
//  config   | cfg_write            | cfg_data (max_length)
//
// One item per cycle sustained while the result register is not stalled. An item
// passes through the input register and then the result register.
// The parse step runs once per item between the two registers.
// A stalled result register holds the input register; in_ready then drops.
// Reset sets max_length to 65536 and the parser to the length phase.
// ----------------------------------------------------------------------------
`default_nettype none

module netstring_deframer_unit
  import ndf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic              end_of_stream,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      data_byte,
  output logic                   data_valid,
  output logic                   string_done,
  output logic [LEN_W-1:0]       string_length,
  output logic [ERR_W-1:0]       error_code,
  input  wire logic              cfg_write,
  input  wire logic [LEN_W-1:0]  cfg_data
);

  logic [LEN_W-1:0]   max_length;

  logic               s1_valid;
  logic [BYTE_W-1:0]  s1_byte;
  logic               s1_eos;
  logic               s1_advance;

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [DIGIT_W-1:0] digit_count;
  logic [DIGIT_W-1:0] digit_count_next;
  logic [ACC_W-1:0]   length_value;
  logic [ACC_W-1:0]   length_value_next;
  logic [ACC_W-1:0]   bytes_left;
  logic [ACC_W-1:0]   bytes_left_next;

  result_t            result;
  result_t            result_next;
  logic               emit;

  logic               is_digit;
  logic [PROD_W-1:0]  lv_ext;
  logic [PROD_W-1:0]  lv_prod;
  logic [ACC_W-1:0]   lv_sat;
  logic [ACC_W-1:0]   max_ext;
  logic [ACC_W-1:0]   bl_dec;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  assign is_digit = !s1_eos && (s1_byte >= CHAR_ZERO) && (s1_byte <= CHAR_NINE);
  assign lv_ext   = {{(PROD_W-ACC_W){1'b0}}, length_value};
  assign lv_prod  = (lv_ext << 3) + (lv_ext << 1)
                  + {{(PROD_W-DIGIT_W){1'b0}}, s1_byte[DIGIT_W-1:0]};
  assign max_ext  = {1'b0, max_length};
  assign lv_sat   = (lv_prod > {{(PROD_W-ACC_W){1'b0}}, max_ext})
                  ? max_ext + {{(ACC_W-1){1'b0}}, 1'b1}
                  : lv_prod[ACC_W-1:0];
  assign bl_dec   = bytes_left - {{(ACC_W-1){1'b0}}, 1'b1};

  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    length_value_next = length_value;
    bytes_left_next   = bytes_left;
    emit              = 1'b0;
    result_next       = '0;
    unique case (phase)
      PH_LENGTH: begin
        if (is_digit) begin
          if (digit_count >= MAX_DIGITS) begin
            emit                   = 1'b1;
            result_next.error_code = ERR_TOO_MANY;
            phase_next             = PH_FAILED;
          end else begin
            digit_count_next  = digit_count + {{(DIGIT_W-1){1'b0}}, 1'b1};
            length_value_next = lv_sat;
          end
        end else if (s1_eos || s1_byte != CHAR_COLON) begin
          emit                   = 1'b1;
          result_next.error_code = ERR_NO_COLON;
          phase_next             = PH_FAILED;
        end else if (digit_count == '0) begin
          emit                   = 1'b1;
          result_next.error_code = ERR_EMPTY_LEN;
          phase_next             = PH_FAILED;
        end else if (length_value > max_ext) begin
          emit                   = 1'b1;
          result_next.error_code = ERR_TOO_LONG;
          phase_next             = PH_FAILED;
        end else begin
          bytes_left_next = length_value;
          phase_next      = (length_value == '0) ? PH_COMMA : PH_DATA;
        end
      end
      PH_DATA: begin
        emit = 1'b1;
        if (s1_eos) begin
          result_next.error_code = ERR_END_IN_DATA;
          phase_next             = PH_FAILED;
        end else begin
          bytes_left_next        = bl_dec;
          result_next.data_byte  = s1_byte;
          result_next.data_valid = 1'b1;
          if (bl_dec == '0) begin
            phase_next = PH_COMMA;
          end
        end
      end
      PH_COMMA: begin
        emit = 1'b1;
        if (s1_eos || s1_byte != CHAR_COMMA) begin
          result_next.error_code = ERR_NO_COMMA;
          phase_next             = PH_FAILED;
        end else begin
          result_next.string_done   = 1'b1;
          result_next.string_length = length_value[LEN_W-1:0];
          phase_next                = PH_LENGTH;
          digit_count_next          = '0;
          length_value_next         = '0;
          bytes_left_next           = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= byte_in;
      s1_eos  <= end_of_stream;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LENGTH;
      digit_count  <= '0;
      length_value <= '0;
      bytes_left   <= '0;
    end else if (s1_advance) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      length_value <= length_value_next;
      bytes_left   <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      result <= result_next;
    end
  end

  assign data_byte     = result.data_byte;
  assign data_valid    = result.data_valid;
  assign string_done   = result.string_done;
  assign string_length = result.string_length;
  assign error_code    = result.error_code;

endmodule

`default_nettype wire
